// ===== design/linear_queue_with_search_top_defines.svh =====
// Assertion helpers for the file that checks behavior.
`ifndef LINEAR_QUEUE_WITH_SEARCH_TOP_DEFINES_SVH
`define LINEAR_QUEUE_WITH_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LQS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lqs_pkg.sv =====
`default_nettype none

package lqs_pkg;

   // Store geometry.
   localparam int DEPTH  = 64;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // Field widths.
   localparam int VALUE_W    = 32;
   localparam int ACTION_W   = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_OUT_W = 6;
   localparam int CAP_W      = 7;
   localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Command queue between front and back (depth is a power of two).
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Action codes on the request channel.
   localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DISPLAY = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SEARCH  = 2'd3;

   typedef enum logic [1:0] {
      OP_ENQUEUE,
      OP_DEQUEUE,
      OP_DISPLAY,
      OP_SEARCH
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // One classified request handed from the front to the back.
   typedef struct packed {
      logic                      valid;
      op_type                    op;
      logic signed [VALUE_W-1:0] operand;
   } cmd_type;

   // Maps an internal slot number onto the response slot field.
   function automatic logic [SLOT_OUT_W-1:0] to_slot_out(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+SLOT_OUT_W-1:0] wide;
      wide = {{SLOT_OUT_W{1'b0}}, s};
      return wide[SLOT_OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/lqs_req_if.sv =====
`default_nettype none

interface lqs_req_if;
   import lqs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ACTION_W-1:0]       action;
   logic signed [VALUE_W-1:0] operand_value;

   modport source (output valid, action, operand_value, input ready);
   modport sink   (input valid, action, operand_value, output ready);
endinterface

`default_nettype wire

// ===== design/lqs_rsp_if.sv =====
`default_nettype none

interface lqs_rsp_if;
   import lqs_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] item_value;
   logic [SLOT_OUT_W-1:0]     slot_index;
   logic                      last_result;

   modport source (output valid, status, item_value, slot_index, last_result, input ready);
   modport sink   (input valid, status, item_value, slot_index, last_result, output ready);
endinterface

`default_nettype wire

// ===== design/lqs_front.sv =====
`default_nettype none

module lqs_front (
   input  wire logic       clock,
   input  wire logic       reset,
   lqs_req_if.sink         req_ch,
   output lqs_pkg::cmd_type cmd,
   input  wire logic       pop
);
   import lqs_pkg::*;

   op_type                    op_q_ff      [CMDQ_DEPTH];
   logic signed [VALUE_W-1:0] operand_q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0]     count_ff, count_in;
   logic                      push;
   logic                      do_pop;
   op_type                    req_op;

   // Decode the action code into an operation.
   always_comb begin
      unique case (req_ch.action)
         ACT_ENQUEUE: req_op = OP_ENQUEUE;
         ACT_DEQUEUE: req_op = OP_DEQUEUE;
         ACT_DISPLAY: req_op = OP_DISPLAY;
         ACT_SEARCH:  req_op = OP_SEARCH;
         default:     req_op = OP_ENQUEUE;
      endcase
   end

   // A request is taken whenever the command queue has room.
   assign req_ch.ready = (count_ff != CMDQ_CNT_W'(CMDQ_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign do_pop       = pop && (count_ff != '0);

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + CMDQ_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + CMDQ_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue entries hold payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         op_q_ff[wr_ptr_ff]      <= req_op;
         operand_q_ff[wr_ptr_ff] <= req_ch.operand_value;
      end
   end

   // The oldest entry is offered to the back.
   always_comb begin
      cmd.valid   = (count_ff != '0);
      cmd.op      = op_q_ff[rd_ptr_ff];
      cmd.operand = operand_q_ff[rd_ptr_ff];
   end

endmodule

`default_nettype wire

// ===== design/lqs_back.sv =====
`default_nettype none

module lqs_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [lqs_pkg::CAP_W-1:0]  csr_wdata,
   input  wire lqs_pkg::cmd_type           cmd,
   output logic                            pop,
   lqs_rsp_if.source                       rsp_ch
);
   import lqs_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DEQ,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [SLOT_W-1:0]         head_ff, head_in;
   logic [SLOT_W-1:0]         tail_ff, tail_in;
   logic                      empty_ff, empty_in;
   logic [CAP_W-1:0]          cap_ff;
   logic [SLOT_W-1:0]         cur_ff, cur_in;
   logic                      search_ff, search_in;
   logic signed [VALUE_W-1:0] target_ff, target_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]         pend_slot_ff, pend_slot_in;

   logic                      out_valid_ff, out_valid_in;
   status_type                out_status_ff, out_status_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic [SLOT_W-1:0]         out_slot_ff, out_slot_in;
   logic                      out_last_ff, out_last_in;

   logic signed [VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      rd_en;
   logic [SLOT_W-1:0]         rd_addr;
   logic                      wr_en;
   logic [SLOT_W-1:0]         wr_addr;

   logic                      out_free;
   logic [CMP_W-1:0]          cap_ext;
   logic [CMP_W-1:0]          usable;
   logic [CMP_W-1:0]          tail_next_ext;
   logic                      enq_full;
   logic [SLOT_W-1:0]         enq_slot;
   logic                      at_tail;
   logic                      match;

   // Usable slot count and the overflow test for enqueue.
   always_comb begin
      cap_ext       = CMP_W'(cap_ff);
      usable        = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
      tail_next_ext = CMP_W'(tail_ff) + CMP_W'(1);
      enq_full      = (usable == '0) || (!empty_ff && (tail_next_ext >= usable));
      enq_slot      = empty_ff ? '0 : tail_ff + SLOT_W'(1);
   end

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign at_tail  = (cur_ff == tail_ff);
   assign match    = (rd_data_ff == target_ff);

   // Sequencer: enqueue from idle, dequeue through S_DEQ, scans one slot per cycle unless a response stalls.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      empty_in      = empty_ff;
      cur_in        = cur_ff;
      search_in     = search_ff;
      target_in     = target_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_slot_in   = out_slot_ff;
      out_last_in   = out_last_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;
      wr_en         = 1'b0;
      wr_addr       = enq_slot;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd.valid && out_free) begin
               pop = 1'b1;
               case (cmd.op)
                  OP_ENQUEUE: begin
                     out_valid_in = 1'b1;
                     out_last_in  = 1'b1;
                     if (enq_full) begin
                        out_status_in = ST_OVERFLOW;
                        out_value_in  = '0;
                        out_slot_in   = '0;
                     end else begin
                        wr_en         = 1'b1;
                        tail_in       = enq_slot;
                        empty_in      = 1'b0;
                        if (empty_ff) begin
                           head_in = '0;
                        end
                        out_status_in = ST_OK;
                        out_value_in  = cmd.operand;
                        out_slot_in   = enq_slot;
                     end
                  end
                  default: begin
                     if (empty_ff) begin
                        // Nothing held: a single empty result.
                        out_valid_in  = 1'b1;
                        out_status_in = ST_EMPTY;
                        out_value_in  = '0;
                        out_slot_in   = '0;
                        out_last_in   = 1'b1;
                     end else begin
                        rd_en         = 1'b1;
                        rd_addr       = head_ff;
                        cur_in        = head_ff;
                        search_in     = (cmd.op == OP_SEARCH);
                        target_in     = cmd.operand;
                        pend_valid_in = 1'b0;
                        state_in      = (cmd.op == OP_DEQUEUE) ? S_DEQ : S_SCAN;
                     end
                  end
               endcase
            end
         end

         S_DEQ: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = ST_OK;
               out_value_in  = rd_data_ff;
               out_slot_in   = head_ff;
               out_last_in   = 1'b1;
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else begin
                  head_in = head_ff + SLOT_W'(1);
               end
               state_in = S_IDLE;
            end
         end

         S_SCAN: begin
            if (!search_ff) begin
               // Display: every held slot in order.
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_status_in = ST_OK;
                  out_value_in  = rd_data_ff;
                  out_slot_in   = cur_ff;
                  out_last_in   = at_tail;
                  if (at_tail) begin
                     state_in = S_IDLE;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = cur_ff + SLOT_W'(1);
                     cur_in  = cur_ff + SLOT_W'(1);
                  end
               end
            end else if (!(match && pend_valid_ff && !out_free)) begin
               // Search: a match is held back until the next one shows which is last.
               if (match) begin
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_status_in = ST_OK;
                     out_value_in  = target_ff;
                     out_slot_in   = pend_slot_ff;
                     out_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = cur_ff;
               end
               if (at_tail) begin
                  state_in = S_FINISH;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = cur_ff + SLOT_W'(1);
                  cur_in  = cur_ff + SLOT_W'(1);
               end
            end
         end

         S_FINISH: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b1;
               if (pend_valid_ff) begin
                  out_status_in = ST_OK;
                  out_value_in  = target_ff;
                  out_slot_in   = pend_slot_ff;
               end else begin
                  out_status_in = ST_NOT_FOUND;
                  out_value_in  = '0;
                  out_slot_in   = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, indices, capacity register and the response register.
   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      search_ff     <= search_in;
      target_ff     <= target_in;
      pend_slot_ff  <= pend_slot_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_slot_ff   <= out_slot_in;
      out_last_ff   <= out_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         empty_ff      <= 1'b1;
         cap_ff        <= CAP_RESET;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         empty_ff      <= empty_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // Value store with one write port and a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= cmd.operand;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.status      = out_status_ff;
   assign rsp_ch.item_value  = out_value_ff;
   assign rsp_ch.slot_index  = to_slot_out(out_slot_ff);
   assign rsp_ch.last_result = out_last_ff;

endmodule

`default_nettype wire

// ===== design/linear_queue_with_search_top.sv =====
// Channel   Dir   Handshake           Payload
// req_ch    in    valid/ready         action, operand_value
// rsp_ch    out   valid/ready         status, item_value, slot_index, last_result
// csr       in    csr_we (no wait)    csr_wdata = capacity
//
// Enqueue completes from idle; dequeue passes through S_DEQ in the back, set by the
// registered read port of the value store. Display reads from the head to the tail,
// and search ends in S_FINISH; the front keeps taking up to 2 requests meanwhile.
// Reset is synchronous and active high; the queue comes up empty with capacity 64.
// A stalled response holds the back but not the front until its queue is full.
`default_nettype none

`include "linear_queue_with_search_top_defines.svh"

module linear_queue_with_search_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   lqs_req_if.sink                        req_ch,
   lqs_rsp_if.source                      rsp_ch,
   input  wire logic                      csr_we,
   input  wire logic [lqs_pkg::CAP_W-1:0] csr_wdata
);
   import lqs_pkg::*;

   cmd_type cmd;
   logic    pop;

   // Front: takes and classifies requests into a short command queue.
   lqs_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .cmd    (cmd),
      .pop    (pop)
   );

   // Back: runs commands against the store and drives responses.
   lqs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

   // Checks on the link between front and back, on enqueue responses and on error responses.
   `LQS_ASSERT_NOW(a_pop_needs_cmd, clock, reset, pop, cmd.valid, "pop without a command")
   `LQS_ASSERT_NEXT(a_enq_responds, clock, reset, pop && (cmd.op == OP_ENQUEUE), rsp_ch.valid, "enqueue gave no response")
   `LQS_ASSERT_NOW(a_err_is_last, clock, reset, rsp_ch.valid && (rsp_ch.status != ST_OK), rsp_ch.last_result, "error response not last")
   `LQS_ASSERT_NOW(a_err_zero, clock, reset, rsp_ch.valid && (rsp_ch.status != ST_OK), (rsp_ch.item_value == '0) && (rsp_ch.slot_index == '0), "error response carries data")

endmodule

`default_nettype wire
